// File: src/source_byte_tokenizer_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define SBT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbt assertion failed");

// Checked in every cycle, reset included.
`define SBT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sbt reset assertion failed");

`endif

// File: src/sbt_pkg.sv
package sbt_pkg;

  localparam int LINE_BITS_DEF = 20;

  typedef enum logic [3:0] {
    M_IDLE,
    M_OP,
    M_IDENT,
    M_NUMBER,
    M_STRING,
    M_ESC,
    M_LINEC,
    M_BLOCK,
    M_STAR
  } lex_mode_t;

  typedef logic [3:0] op_idx_t;

  localparam op_idx_t OP_NONE  = 4'd0;
  localparam op_idx_t OP_SLASH = 4'd8;
  localparam op_idx_t OP_MAX   = 4'd10;

  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_SEMI     = 6'd1;
  localparam logic [5:0] K_COMMA    = 6'd2;
  localparam logic [5:0] K_DOT      = 6'd3;
  localparam logic [5:0] K_CARET    = 6'd10;
  localparam logic [5:0] K_LPAREN   = 6'd25;
  localparam logic [5:0] K_RPAREN   = 6'd26;
  localparam logic [5:0] K_LBRACK   = 6'd27;
  localparam logic [5:0] K_RBRACK   = 6'd28;
  localparam logic [5:0] K_LBRACE   = 6'd29;
  localparam logic [5:0] K_RBRACE   = 6'd30;
  localparam logic [5:0] K_COLON    = 6'd31;
  localparam logic [5:0] K_STRING   = 6'd32;
  localparam logic [5:0] K_IDENT    = 6'd33;
  localparam logic [5:0] K_NUMBER   = 6'd34;
  localparam logic [5:0] K_KEYWORD0 = 6'd35;
  localparam logic [5:0] K_UNKNOWN  = 6'd44;

  localparam int KW_NUM = 9;
  localparam logic [71:0] KW_STR [KW_NUM] = '{
    "type", "if", "ifn", "int8", "else", "for", "while", "return", "namespace"
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd4, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd9
  };

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [5:0] kind;
    logic       is_text;
    logic [7:0] text;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t tok(input logic [5:0] kind);
    res_t r;
    r.kind    = kind;
    r.is_text = 1'b0;
    r.text    = 8'h00;
    return r;
  endfunction

  function automatic res_t txt(input logic [7:0] b);
    res_t r;
    r.kind    = K_EOF;
    r.is_text = 1'b1;
    r.text    = b;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic op_idx_t op_index(input logic [7:0] c);
    op_idx_t r;
    unique case (c)
      "=":     r = 4'd1;
      "&":     r = 4'd2;
      "|":     r = 4'd3;
      "!":     r = 4'd4;
      "+":     r = 4'd5;
      "-":     r = 4'd6;
      "*":     r = 4'd7;
      "/":     r = 4'd8;
      "<":     r = 4'd9;
      ">":     r = 4'd10;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_second(input op_idx_t i);
    logic [7:0] r;
    unique case (i)
      4'd2:    r = "&";
      4'd3:    r = "|";
      default: r = "=";
    endcase
    return r;
  endfunction

  // two-char kind is the one-char kind minus one
  function automatic logic [5:0] op_one(input op_idx_t i);
    logic [5:0] r;
    unique case (i)
      4'd1:    r = 6'd5;
      4'd2:    r = 6'd7;
      4'd3:    r = 6'd9;
      default: r = 6'({2'b00, i}) + 6'({2'b00, i}) + 6'd4;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] op_two(input op_idx_t i);
    return op_one(i) - 6'd1;
  endfunction

  // {known, byte}
  function automatic logic [8:0] esc_byte(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      "n":     r = {1'b1, 8'h0A};
      "t":     r = {1'b1, 8'h09};
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      "v":     r = {1'b1, 8'h0B};
      "r":     r = {1'b1, 8'h0D};
      "f":     r = {1'b1, 8'h0C};
      "0":     r = {1'b1, 8'h00};
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

endpackage

// File: src/sbt_if.sv
interface sbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

interface sbt_out_if import sbt_pkg::*; #(parameter int LINE_BITS = LINE_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [5:0]           token_kind;
  logic                 is_text;
  logic [7:0]           text_byte;
  logic [LINE_BITS-1:0] line_number;
  logic                 last;

  modport source (output valid, output token_kind, output is_text, output text_byte,
                  output line_number, output last, input ready);
  modport sink (input valid, input token_kind, input is_text, input text_byte,
                input line_number, input last, output ready);
endinterface

// File: src/sbt_lex_core.sv
module sbt_lex_core import sbt_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           c,
  output push_t                push,
  output logic [LINE_BITS-1:0] line
);

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  lex_mode_t            mode_r, mode_nxt;
  op_idx_t              pend_r, pend_nxt;
  logic [KW_NUM-1:0]    mask_r, mask_nxt;
  logic [3:0]           len_r, len_nxt;
  logic                 dot_r, dot_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  logic              pre_v, st_v, do_start, clear;
  res_t              pre, st;
  logic [KW_NUM-1:0] kw_hit, feed_mask;
  logic [3:0]        base_len, feed_len;
  logic [5:0]        ident_kind;
  logic [8:0]        esc;
  op_idx_t           c_op;
  logic              pend_ok, alnum;

  assign c_op    = op_index(c);
  assign esc     = esc_byte(c);
  assign alnum   = is_alpha(c) || is_digit(c);
  assign pend_ok = pend_r != OP_NONE && pend_r <= OP_MAX;

  // keyword match, continuing an identifier or starting a fresh one
  assign base_len = (mode_r == M_IDENT) ? len_r : 4'd0;

  always_comb begin
    logic [3:0] pos;
    for (int k = 0; k < KW_NUM; k++) begin
      pos       = (base_len < KW_LEN[k]) ? KW_LEN[k] - 4'd1 - base_len : 4'd0;
      kw_hit[k] = (base_len < KW_LEN[k]) && (KW_STR[k][pos*8 +: 8] == c);
    end
  end

  assign feed_mask = ((mode_r == M_IDENT) ? mask_r : {KW_NUM{1'b1}}) & kw_hit;
  assign feed_len  = (base_len == 4'd15) ? 4'd15 : base_len + 4'd1;

  always_comb begin
    ident_kind = K_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (mask_r[k] && KW_LEN[k] == len_r) ident_kind = K_KEYWORD0 + 6'(k);
    end
  end

  // results from the current mode
  always_comb begin
    pre_v    = 1'b0;
    pre      = tok(K_EOF);
    do_start = 1'b0;
    unique case (mode_r)
      M_IDLE: do_start = 1'b1;
      M_OP: begin
        if (!pend_ok) begin
          do_start = 1'b1;
        end else if (pend_r == OP_SLASH && (c == "/" || c == "*")) begin
          pre_v = 1'b0;
        end else if (c == op_second(pend_r)) begin
          pre_v = 1'b1;
          pre   = tok(op_two(pend_r));
        end else begin
          pre_v    = 1'b1;
          pre      = tok(op_one(pend_r));
          do_start = 1'b1;
        end
      end
      M_IDENT: begin
        pre_v = 1'b1;
        if (alnum) begin
          pre = txt(c);
        end else begin
          pre      = tok(ident_kind);
          do_start = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(c)) begin
          pre_v = 1'b1;
          pre   = txt(c);
        end else if (c == ".") begin
          pre_v = !dot_r;
          pre   = txt(c);
        end else begin
          pre_v    = 1'b1;
          pre      = tok(K_NUMBER);
          do_start = 1'b1;
        end
      end
      M_STRING: begin
        if (c == 8'h22) begin
          pre_v = 1'b1;
          pre   = tok(K_STRING);
        end else if (c == 8'h5C) begin
          pre_v = 1'b0;
        end else if (c == 8'h00) begin
          pre_v    = 1'b1;
          pre      = tok(K_STRING);
          do_start = 1'b1;
        end else begin
          pre_v = 1'b1;
          pre   = txt(c);
        end
      end
      M_ESC: begin
        if (c == 8'h00) begin
          pre_v    = 1'b1;
          pre      = tok(K_STRING);
          do_start = 1'b1;
        end else begin
          pre_v = esc[8];
          pre   = txt(esc[7:0]);
        end
      end
      M_LINEC, M_BLOCK, M_STAR: do_start = (c == 8'h00);
      default: do_start = 1'b1;
    endcase
  end

  // result of a byte that arrives between tokens
  always_comb begin
    st_v = do_start;
    st   = tok(K_UNKNOWN);
    priority if (c_op != OP_NONE) begin
      st_v = 1'b0;
    end else if (is_alpha(c) || is_digit(c)) begin
      st = txt(c);
    end else if (is_space(c) || c == 8'h22) begin
      st_v = 1'b0;
    end else begin
      unique case (c)
        8'h00:   st = tok(K_EOF);
        ";":     st = tok(K_SEMI);
        ",":     st = tok(K_COMMA);
        ".":     st = tok(K_DOT);
        "^":     st = tok(K_CARET);
        "(":     st = tok(K_LPAREN);
        ")":     st = tok(K_RPAREN);
        "[":     st = tok(K_LBRACK);
        "]":     st = tok(K_RBRACK);
        "{":     st = tok(K_LBRACE);
        "}":     st = tok(K_RBRACE);
        ":":     st = tok(K_COLON);
        default: st = tok(K_UNKNOWN);
      endcase
    end
  end

  assign clear = do_start && c == 8'h00;

  // next state
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    mask_nxt = mask_r;
    len_nxt  = len_r;
    dot_nxt  = dot_r;
    unique case (mode_r)
      M_OP: begin
        pend_nxt = OP_NONE;
        mode_nxt = M_IDLE;
        if (pend_r == OP_SLASH && c == "/") mode_nxt = M_LINEC;
        if (pend_r == OP_SLASH && c == "*") mode_nxt = M_BLOCK;
      end
      M_IDENT: begin
        if (alnum) begin
          mask_nxt = feed_mask;
          len_nxt  = feed_len;
        end
      end
      M_NUMBER: if (c == ".") dot_nxt = 1'b1;
      M_STRING: begin
        if (c == 8'h22) mode_nxt = M_IDLE;
        else if (c == 8'h5C) mode_nxt = M_ESC;
      end
      M_ESC:   mode_nxt = M_STRING;
      M_LINEC: if (c == 8'h0A) mode_nxt = M_IDLE;
      M_BLOCK: if (c == "*") mode_nxt = M_STAR;
      M_STAR: begin
        if (c == "/") mode_nxt = M_IDLE;
        else if (c != "*") mode_nxt = M_BLOCK;
      end
      default: mode_nxt = mode_r;
    endcase

    if (do_start) begin
      mode_nxt = M_IDLE;
      priority if (c_op != OP_NONE) begin
        pend_nxt = c_op;
        mode_nxt = M_OP;
      end else if (is_alpha(c)) begin
        mode_nxt = M_IDENT;
        mask_nxt = feed_mask;
        len_nxt  = feed_len;
      end else if (is_digit(c)) begin
        mode_nxt = M_NUMBER;
        dot_nxt  = 1'b0;
      end else if (c == 8'h22) begin
        mode_nxt = M_STRING;
      end else if (clear) begin
        pend_nxt = OP_NONE;
        mask_nxt = {KW_NUM{1'b1}};
        len_nxt  = 4'd0;
        dot_nxt  = 1'b0;
      end else begin
        mode_nxt = M_IDLE;
      end
    end
  end

  always_comb begin
    line_nxt = line_r;
    if (clear) line_nxt = LINE_ONE;
    else if (c == 8'h0A && line_r != LINE_MAX) line_nxt = line_r + LINE_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= OP_NONE;
      mask_r <= {KW_NUM{1'b1}};
      len_r  <= 4'd0;
      dot_r  <= 1'b0;
      line_r <= LINE_ONE;
    end else if (step) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      mask_r <= mask_nxt;
      len_r  <= len_nxt;
      dot_r  <= dot_nxt;
      line_r <= line_nxt;
    end
  end

  assign push.n  = {pre_v & st_v, pre_v ^ st_v};
  assign push.r0 = pre_v ? pre : st;
  assign push.r1 = st;
  assign line    = line_r;

endmodule

// File: src/sbt_res_fifo.sv
module sbt_res_fifo import sbt_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  push_t                push,
  input  logic [LINE_BITS-1:0] push_line,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res,
  output logic [LINE_BITS-1:0] out_line,
  output logic                 out_last
);

  res_t                 res_q  [FIFO_DEPTH];
  logic [LINE_BITS-1:0] line_q [FIFO_DEPTH];
  logic                 last_q [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wr_r, rd_r, wr_p1;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt, push_n;
  logic               pop;

  assign pop    = out_valid && out_ready;
  assign push_n = push_en ? {{(FIFO_AW - 1){1'b0}}, push.n} : '0;
  assign wr_p1  = wr_r + FIFO_AW'(1);

  assign cnt_nxt = cnt_r + push_n - {{FIFO_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push_n[FIFO_AW-1:0];
      rd_r  <= rd_r + {{(FIFO_AW - 1){1'b0}}, pop};
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && push.n != 2'd0) begin
      res_q[wr_r]  <= push.r0;
      line_q[wr_r] <= push_line;
      last_q[wr_r] <= push.n == 2'd1;
    end
    if (push_en && push.n == 2'd2) begin
      res_q[wr_p1]  <= push.r1;
      line_q[wr_p1] <= push_line;
      last_q[wr_p1] <= 1'b1;
    end
  end

  assign room      = cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_res   = res_q[rd_r];
  assign out_line  = line_q[rd_r];
  assign out_last  = last_q[rd_r];

endmodule

// File: src/source_byte_tokenizer_unit.sv
// A result is registered in the result queue when its source byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is not stalled; two results of one byte leave in turn by the single port.
// A four-entry result queue decouples the sides; in_ready needs two free entries.
// Reset (rst_n low, synchronous): lexer idle, line count one, queue empty.
module source_byte_tokenizer_unit import sbt_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  sbt_in_if.sink   in_chan,
  sbt_out_if.source out_chan
);

  push_t                push;
  logic [LINE_BITS-1:0] line;
  logic                 room, step;
  res_t                 out_res;

  assign step          = in_chan.valid && room;
  assign in_chan.ready = room;

  sbt_lex_core #(.LINE_BITS(LINE_BITS)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .c     (in_chan.src_byte),
    .push  (push),
    .line  (line)
  );

  sbt_res_fifo #(.LINE_BITS(LINE_BITS)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (step),
    .push      (push),
    .push_line (line),
    .room      (room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res),
    .out_line  (out_chan.line_number),
    .out_last  (out_chan.last)
  );

  assign out_chan.token_kind = out_res.kind;
  assign out_chan.is_text    = out_res.is_text;
  assign out_chan.text_byte  = out_res.text;

endmodule

// File: src/sbt_checker.sv
`include "source_byte_tokenizer_unit_defines.svh"

module sbt_checker import sbt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_token_kind,
  input logic       out_is_text,
  input logic [7:0] out_text_byte,
  input logic       out_last
);

  `SBT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_text_byte))
  `SBT_ASSERT(a_eof_last, out_valid && !out_is_text && out_token_kind == K_EOF |-> out_last)
  `SBT_ASSERT(a_empty_ready, !out_valid |-> in_ready)
  `SBT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind source_byte_tokenizer_unit sbt_checker u_sbt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_token_kind (out_chan.token_kind),
  .out_is_text    (out_chan.is_text),
  .out_text_byte  (out_chan.text_byte),
  .out_last       (out_chan.last)
);
